// File: rtl/lvkt_pkg.sv
// ----------------------------------------------------------------------------
// lvkt_pkg
// Shared types and constants of the LRU voxel key table.
// ----------------------------------------------------------------------------
package lvkt_pkg;

  localparam int TableDepth   = 4096;
  localparam int KeyWidth     = 16;
  localparam int CoordWidth   = 24;
  localparam int InvWidth     = 16;
  localparam int CapWidth     = 13;
  localparam int SlotWidth    = 12;
  localparam int OccWidth     = 13;
  localparam int CfgIdxWidth  = 4;
  localparam int CfgDataWidth = 16;
  localparam int ProdWidth    = CoordWidth + InvWidth + 1;

  localparam logic [InvWidth-1:0] InvResReset   = InvWidth'(512);
  localparam logic [CapWidth-1:0] CapacityReset = CapWidth'(4096);

  typedef enum logic [CfgIdxWidth-1:0] {
    RegInvRes   = CfgIdxWidth'(0),
    RegCapacity = CfgIdxWidth'(1)
  } cfg_reg_e;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MUL,
    ST_ROUND,
    ST_SCAN,
    ST_HIT_RD,
    ST_HIT_LINK,
    ST_HIT_UNLINK,
    ST_HIT_TAIL,
    ST_HIT_HEAD,
    ST_INS_KEY,
    ST_INS_HEAD,
    ST_EV_RD,
    ST_EV_DATA,
    ST_EV_LINK,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [CfgIdxWidth-1:0]  index;
    logic [CfgDataWidth-1:0] value;
  } cfg_t;

  typedef struct packed {
    logic signed [CoordWidth-1:0] point_x;
    logic signed [CoordWidth-1:0] point_y;
    logic signed [CoordWidth-1:0] point_z;
  } point_t;

  typedef struct packed {
    logic signed [KeyWidth-1:0] key_x;
    logic signed [KeyWidth-1:0] key_y;
    logic signed [KeyWidth-1:0] key_z;
    logic                       hit;
    logic [SlotWidth-1:0]       slot;
    logic                       evicted;
    logic signed [KeyWidth-1:0] evicted_x;
    logic signed [KeyWidth-1:0] evicted_y;
    logic signed [KeyWidth-1:0] evicted_z;
    logic [OccWidth-1:0]        occupancy;
  } result_t;

endpackage

// File: rtl/lvkt_stream_if.sv
// ----------------------------------------------------------------------------
// lvkt_stream_if
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface lvkt_stream_if #(
  parameter type data_t = logic
);
  logic  valid;
  logic  ready;
  data_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/lru_voxel_key_table_core.sv
// ----------------------------------------------------------------------------
// lru_voxel_key_table_core
// Voxel key quantizer with an exact-match table kept in LRU order.
// ----------------------------------------------------------------------------
// Each point is quantized to a voxel key (multiply, then round and saturate)
// and looked up by scanning the key memory one slot per cycle from slot 0.
// The scan stops at the matching slot, or once every held key has been seen
// and a free slot found, and is followed by any recency-list updates in the
// link memory; with an occupancy of n the scan covers at most n + 1 slots.
// Keys and valid flags sit in one memory and the newer/older links in a
// second, both single write port with a registered read. After reset a
// clearing pass writes every slot of the key memory, during which no point
// is accepted; configuration writes are taken at any time. A finished result
// waits in an output register while the next point is accepted.
module lru_voxel_key_table_core #(
  parameter int TABLE_DEPTH = lvkt_pkg::TableDepth
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  lvkt_stream_if.sink           cfg_i,
  lvkt_stream_if.sink           point_i,
  lvkt_stream_if.source         result_o
);

  localparam int IW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW   = $clog2(TABLE_DEPTH + 1);
  localparam int KW   = lvkt_pkg::KeyWidth;
  localparam int PW   = lvkt_pkg::ProdWidth;
  localparam int RW   = PW - 16;
  localparam int WW   = 3 * KW + 1;
  localparam logic [RW-1:0] NegMag = RW'(1) << (KW - 1);
  localparam logic [RW-1:0] PosMax = NegMag - RW'(1);
  localparam logic [IW-1:0] LastSlot = IW'(TABLE_DEPTH - 1);

  function automatic logic [KW-1:0] round_key(input logic signed [PW-1:0] p);
    logic [PW-1:0] mag;
    logic [PW-1:0] sum;
    logic [RW-1:0] r;
    logic [RW-1:0] neg;
    mag = p[PW-1] ? PW'(-p) : PW'(p);
    sum = mag + PW'(32768);
    r   = sum[PW-1:16];
    if (p[PW-1]) begin
      if (r > NegMag) r = NegMag;
      neg = RW'(0) - r;
      return neg[KW-1:0];
    end
    if (r > PosMax) r = PosMax;
    return r[KW-1:0];
  endfunction

  lvkt_pkg::state_e state_q, state_d;

  logic [lvkt_pkg::InvWidth-1:0] inv_q;
  logic [lvkt_pkg::CapWidth-1:0] cap_q;

  logic [WW-1:0]     key_mem [TABLE_DEPTH];
  logic [2*IW-1:0]   link_mem [TABLE_DEPTH];

  logic              key_we;
  logic [IW-1:0]     key_waddr, key_raddr;
  logic [WW-1:0]     key_wdata, key_rd_q;
  logic              link_we_newer, link_we_older;
  logic [IW-1:0]     link_waddr, link_raddr;
  logic [IW-1:0]     link_wnewer, link_wolder;
  logic [2*IW-1:0]   link_rd_q;

  lvkt_pkg::point_t  pt_q, pt_d;
  logic signed [PW-1:0] px_q, py_q, pz_q, px_d, py_d, pz_d;
  logic [KW-1:0]     kx_q, ky_q, kz_q, kx_d, ky_d, kz_d;
  logic [KW-1:0]     ex_q, ey_q, ez_q, ex_d, ey_d, ez_d;

  logic [IW-1:0]     clr_q, clr_d;
  logic [IW-1:0]     scan_addr_q, scan_addr_d, chk_idx_q, chk_idx_d;
  logic              pend_q, pend_d;
  logic [CW-1:0]     seen_q, seen_d;
  logic              free_found_q, free_found_d;
  logic [IW-1:0]     free_idx_q, free_idx_d;
  logic              hit_q, hit_d, evict_q, evict_d;
  logic [IW-1:0]     slot_q, slot_d;
  logic [IW-1:0]     nb_q, nb_d, ob_q, ob_d;
  logic [IW-1:0]     newest_q, newest_d, oldest_q, oldest_d;
  logic [CW-1:0]     count_q, count_d;
  lvkt_pkg::result_t res_q, res_d;
  logic              res_valid_q, res_valid_d;

  logic              rd_valid, rd_match, scan_stop, scan_hit;
  logic [CW-1:0]     seen_nx;
  logic              free_found_nx;
  logic [IW-1:0]     free_idx_nx;
  logic              res_free;
  logic [IW-1:0]     rd_newer, rd_older;

  assign cfg_i.ready    = 1'b1;
  assign point_i.ready  = (state_q == lvkt_pkg::ST_IDLE);
  assign result_o.valid = res_valid_q;
  assign result_o.data  = res_q;

  assign rd_valid = key_rd_q[WW-1];
  assign rd_match = rd_valid && (key_rd_q[3*KW-1:0] == {kz_q, ky_q, kx_q});
  assign rd_newer = link_rd_q[2*IW-1:IW];
  assign rd_older = link_rd_q[IW-1:0];
  assign res_free = !res_valid_q || result_o.ready;

  // scan bookkeeping on the word returned for chk_idx_q
  always_comb begin
    seen_nx       = seen_q + CW'(pend_q && rd_valid);
    free_found_nx = free_found_q;
    free_idx_nx   = free_idx_q;
    if (pend_q && !rd_valid && !free_found_q) begin
      free_found_nx = 1'b1;
      free_idx_nx   = chk_idx_q;
    end
    scan_hit  = pend_q && rd_match;
    scan_stop = scan_hit || (pend_q && (seen_nx == count_q) && free_found_nx);
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      lvkt_pkg::ST_CLEAR:      if (clr_q == LastSlot) state_d = lvkt_pkg::ST_IDLE;
      lvkt_pkg::ST_IDLE:       if (point_i.valid) state_d = lvkt_pkg::ST_MUL;
      lvkt_pkg::ST_MUL:        state_d = lvkt_pkg::ST_ROUND;
      lvkt_pkg::ST_ROUND:      state_d = lvkt_pkg::ST_SCAN;
      lvkt_pkg::ST_SCAN: begin
        if (scan_hit) begin
          state_d = (chk_idx_q == newest_q) ? lvkt_pkg::ST_DONE : lvkt_pkg::ST_HIT_RD;
        end else if (scan_stop) begin
          state_d = lvkt_pkg::ST_INS_KEY;
        end
      end
      lvkt_pkg::ST_HIT_RD:     state_d = lvkt_pkg::ST_HIT_LINK;
      lvkt_pkg::ST_HIT_LINK:   state_d = (slot_q == oldest_q) ? lvkt_pkg::ST_HIT_TAIL
                                                              : lvkt_pkg::ST_HIT_UNLINK;
      lvkt_pkg::ST_HIT_UNLINK: state_d = lvkt_pkg::ST_HIT_TAIL;
      lvkt_pkg::ST_HIT_TAIL:   state_d = lvkt_pkg::ST_HIT_HEAD;
      lvkt_pkg::ST_HIT_HEAD:   state_d = lvkt_pkg::ST_DONE;
      lvkt_pkg::ST_INS_KEY: begin
        if (count_q != CW'(0)) state_d = lvkt_pkg::ST_INS_HEAD;
        else state_d = evict_d ? lvkt_pkg::ST_EV_RD : lvkt_pkg::ST_DONE;
      end
      lvkt_pkg::ST_INS_HEAD:   state_d = evict_q ? lvkt_pkg::ST_EV_RD : lvkt_pkg::ST_DONE;
      lvkt_pkg::ST_EV_RD:      state_d = lvkt_pkg::ST_EV_DATA;
      lvkt_pkg::ST_EV_DATA:    state_d = (count_q != CW'(0)) ? lvkt_pkg::ST_EV_LINK
                                                             : lvkt_pkg::ST_DONE;
      lvkt_pkg::ST_EV_LINK:    state_d = lvkt_pkg::ST_DONE;
      lvkt_pkg::ST_DONE:       if (res_free) state_d = lvkt_pkg::ST_IDLE;
      default:                 state_d = lvkt_pkg::ST_CLEAR;
    endcase
  end

  // datapath and memory control
  always_comb begin
    pt_d = pt_q;  px_d = px_q;  py_d = py_q;  pz_d = pz_q;
    kx_d = kx_q;  ky_d = ky_q;  kz_d = kz_q;
    ex_d = ex_q;  ey_d = ey_q;  ez_d = ez_q;
    clr_d = clr_q;
    scan_addr_d = scan_addr_q;  chk_idx_d = chk_idx_q;  pend_d = pend_q;
    seen_d = seen_q;  free_found_d = free_found_q;  free_idx_d = free_idx_q;
    hit_d = hit_q;  evict_d = evict_q;  slot_d = slot_q;
    nb_d = nb_q;  ob_d = ob_q;
    newest_d = newest_q;  oldest_d = oldest_q;  count_d = count_q;
    res_d = res_q;
    res_valid_d = res_valid_q && !result_o.ready;
    key_we = 1'b0;  key_waddr = slot_q;  key_wdata = {1'b1, kz_q, ky_q, kx_q};
    key_raddr = scan_addr_q;
    link_we_newer = 1'b0;  link_we_older = 1'b0;
    link_waddr = slot_q;  link_wnewer = slot_q;  link_wolder = newest_q;
    link_raddr = slot_q;

    case (state_q)
      lvkt_pkg::ST_CLEAR: begin
        key_we    = 1'b1;
        key_waddr = clr_q;
        key_wdata = '0;
        clr_d     = clr_q + IW'(1);
      end
      lvkt_pkg::ST_IDLE: begin
        pt_d = point_i.data;
      end
      lvkt_pkg::ST_MUL: begin
        px_d = PW'(pt_q.point_x) * PW'($signed({1'b0, inv_q}));
        py_d = PW'(pt_q.point_y) * PW'($signed({1'b0, inv_q}));
        pz_d = PW'(pt_q.point_z) * PW'($signed({1'b0, inv_q}));
      end
      lvkt_pkg::ST_ROUND: begin
        kx_d = round_key(px_q);
        ky_d = round_key(py_q);
        kz_d = round_key(pz_q);
        scan_addr_d  = '0;
        pend_d       = 1'b0;
        seen_d       = '0;
        free_found_d = 1'b0;
        free_idx_d   = '0;
        hit_d        = 1'b0;
        evict_d      = 1'b0;
        ex_d = '0;  ey_d = '0;  ez_d = '0;
      end
      lvkt_pkg::ST_SCAN: begin
        key_raddr    = scan_addr_q;
        scan_addr_d  = scan_addr_q + IW'(1);
        chk_idx_d    = scan_addr_q;
        pend_d       = !scan_stop;
        seen_d       = seen_nx;
        free_found_d = free_found_nx;
        free_idx_d   = free_idx_nx;
        if (scan_hit) begin
          hit_d  = 1'b1;
          slot_d = chk_idx_q;
        end else if (scan_stop) begin
          slot_d = free_idx_nx;
        end
      end
      lvkt_pkg::ST_HIT_RD: begin
        link_raddr = slot_q;
      end
      lvkt_pkg::ST_HIT_LINK: begin
        nb_d = rd_newer;
        ob_d = rd_older;
        if (slot_q == oldest_q) begin
          oldest_d = rd_newer;
        end else begin
          link_we_newer = 1'b1;
          link_waddr    = rd_older;
          link_wnewer   = rd_newer;
        end
      end
      lvkt_pkg::ST_HIT_UNLINK: begin
        link_we_older = 1'b1;
        link_waddr    = nb_q;
        link_wolder   = ob_q;
      end
      lvkt_pkg::ST_HIT_TAIL: begin
        link_we_older = 1'b1;
        link_waddr    = slot_q;
        link_wolder   = newest_q;
      end
      lvkt_pkg::ST_HIT_HEAD: begin
        link_we_newer = 1'b1;
        link_waddr    = newest_q;
        link_wnewer   = slot_q;
        newest_d      = slot_q;
      end
      lvkt_pkg::ST_INS_KEY: begin
        key_we    = 1'b1;
        key_waddr = slot_q;
        evict_d   = ({1'b0, count_q} + (CW+1)'(1) >= (CW+1)'(TABLE_DEPTH)) ||
                    (32'(count_q) + 32'd1 >= 32'(cap_q));
        if (count_q == CW'(0)) begin
          oldest_d = slot_q;
          newest_d = slot_q;
        end else begin
          link_we_older = 1'b1;
          link_waddr    = slot_q;
          link_wolder   = newest_q;
        end
      end
      lvkt_pkg::ST_INS_HEAD: begin
        link_we_newer = 1'b1;
        link_waddr    = newest_q;
        link_wnewer   = slot_q;
        newest_d      = slot_q;
      end
      lvkt_pkg::ST_EV_RD: begin
        key_raddr = oldest_q;
      end
      lvkt_pkg::ST_EV_DATA: begin
        ex_d = key_rd_q[KW-1:0];
        ey_d = key_rd_q[2*KW-1:KW];
        ez_d = key_rd_q[3*KW-1:2*KW];
        key_we    = 1'b1;
        key_waddr = oldest_q;
        key_wdata = '0;
        link_raddr = oldest_q;
      end
      lvkt_pkg::ST_EV_LINK: begin
        oldest_d = rd_newer;
      end
      lvkt_pkg::ST_DONE: begin
        if (res_free) begin
          count_d = count_q + CW'(!hit_q) - CW'(evict_q);
          res_valid_d       = 1'b1;
          res_d.key_x       = kx_q;
          res_d.key_y       = ky_q;
          res_d.key_z       = kz_q;
          res_d.hit         = hit_q;
          res_d.slot        = lvkt_pkg::SlotWidth'(slot_q);
          res_d.evicted     = evict_q;
          res_d.evicted_x   = ex_q;
          res_d.evicted_y   = ey_q;
          res_d.evicted_z   = ez_q;
          res_d.occupancy   = lvkt_pkg::OccWidth'(count_q + CW'(!hit_q) - CW'(evict_q));
        end
      end
      default: begin
        clr_d = clr_q;
      end
    endcase
  end

  // configuration transactions
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_q <= lvkt_pkg::InvResReset;
      cap_q <= lvkt_pkg::CapacityReset;
    end else if (cfg_i.valid) begin
      case (lvkt_pkg::cfg_reg_e'(cfg_i.data.index))
        lvkt_pkg::RegInvRes:   inv_q <= cfg_i.data.value[lvkt_pkg::InvWidth-1:0];
        lvkt_pkg::RegCapacity: cap_q <= cfg_i.data.value[lvkt_pkg::CapWidth-1:0];
        default:               inv_q <= inv_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lvkt_pkg::ST_CLEAR;
      clr_q       <= '0;
      pend_q      <= 1'b0;
      newest_q    <= '0;
      oldest_q    <= '0;
      count_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      pend_q      <= pend_d;
      newest_q    <= newest_d;
      oldest_q    <= oldest_d;
      count_q     <= count_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pt_q <= pt_d;  px_q <= px_d;  py_q <= py_d;  pz_q <= pz_d;
    kx_q <= kx_d;  ky_q <= ky_d;  kz_q <= kz_d;
    ex_q <= ex_d;  ey_q <= ey_d;  ez_q <= ez_d;
    scan_addr_q  <= scan_addr_d;
    chk_idx_q    <= chk_idx_d;
    seen_q       <= seen_d;
    free_found_q <= free_found_d;
    free_idx_q   <= free_idx_d;
    hit_q        <= hit_d;
    evict_q      <= evict_d;
    slot_q       <= slot_d;
    nb_q         <= nb_d;
    ob_q         <= ob_d;
    res_q        <= res_d;
  end

  // key memory
  always_ff @(posedge clk_i) begin
    if (key_we) key_mem[key_waddr] <= key_wdata;
    key_rd_q <= key_mem[key_raddr];
  end

  // link memory, newer link in the upper half
  always_ff @(posedge clk_i) begin
    if (link_we_newer) link_mem[link_waddr][2*IW-1:IW] <= link_wnewer;
    if (link_we_older) link_mem[link_waddr][IW-1:0]    <= link_wolder;
    link_rd_q <= link_mem[link_raddr];
  end

`ifndef ASSERT_OFF
  a_count_below_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) < TABLE_DEPTH)
    else $error("occupancy reached table depth");

  a_evict_not_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && res_q.evicted |-> !res_q.hit)
    else $error("eviction reported on a hit");

  a_scan_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == lvkt_pkg::ST_SCAN |=> state_q == lvkt_pkg::ST_SCAN ||
      state_q == lvkt_pkg::ST_HIT_RD || state_q == lvkt_pkg::ST_INS_KEY ||
      state_q == lvkt_pkg::ST_DONE)
    else $error("scan left to an unexpected state");
`endif

endmodule

// File: verif/lvkt_result_checker.sv
// ----------------------------------------------------------------------------
// lvkt_result_checker
// Watches the configuration, point and result channels of the LRU voxel key
// table, keeps its own copy of the table and its recency order, predicts one
// result per accepted point and compares each accepted result against the
// oldest prediction, field by field.
// ----------------------------------------------------------------------------
module lvkt_result_checker
  import lvkt_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  lvkt_stream_if cfg_i,
  lvkt_stream_if point_i,
  lvkt_stream_if result_i,
  output int     fail_count_o,
  output int     pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [InvWidth-1:0]        inv_res;
  logic [CapWidth-1:0]        cap_reg;
  logic signed [KeyWidth-1:0] keys_x [TableDepth];
  logic signed [KeyWidth-1:0] keys_y [TableDepth];
  logic signed [KeyWidth-1:0] keys_z [TableDepth];
  logic                       held   [TableDepth];
  int                         newer  [TableDepth];
  int                         older  [TableDepth];
  int                         head_slot;
  int                         tail_slot;
  int                         held_count;
  result_t                    expected_results[$];

  assign pending_o = expected_results.size();

  function automatic logic signed [KeyWidth-1:0] voxel_key(logic signed [CoordWidth-1:0] c);
    longint prod;
    longint mag;
    longint r;
    prod = longint'(c) * longint'({1'b0, inv_res});
    mag  = (prod < 0) ? -prod : prod;
    r    = (mag + 32768) >> 16;
    if (prod < 0) begin
      if (r > 32768) r = 32768;
      return KeyWidth'(-r);
    end
    if (r > 32767) r = 32767;
    return KeyWidth'(r);
  endfunction

  function automatic int first_free_slot();
    for (int i = 0; i < TableDepth; i++) begin
      if (!held[i]) return i;
    end
    return 0;
  endfunction

  function automatic result_t lookup_point(point_t p);
    result_t r;
    int      s;
    int      n;
    int      o;
    int      cap;
    r       = '0;
    r.key_x = voxel_key(p.point_x);
    r.key_y = voxel_key(p.point_y);
    r.key_z = voxel_key(p.point_z);
    s       = 0;
    for (int i = 0; i < TableDepth; i++) begin
      if (held[i] && keys_x[i] == r.key_x && keys_y[i] == r.key_y && keys_z[i] == r.key_z) begin
        r.hit = 1'b1;
        s     = i;
        break;
      end
    end
    if (r.hit) begin
      if (s != head_slot) begin
        n = newer[s];
        o = older[s];
        if (s == tail_slot) tail_slot = n;
        else begin
          newer[o] = n;
          older[n] = o;
        end
        older[s]         = head_slot;
        newer[head_slot] = s;
        head_slot        = s;
      end
    end else begin
      cap = int'(cap_reg);
      if (cap < 1) cap = 1;
      if (cap > TableDepth) cap = TableDepth;
      s         = first_free_slot();
      keys_x[s] = r.key_x;
      keys_y[s] = r.key_y;
      keys_z[s] = r.key_z;
      held[s]   = 1'b1;
      if (held_count == 0) tail_slot = s;
      else begin
        older[s]         = head_slot;
        newer[head_slot] = s;
      end
      head_slot = s;
      held_count++;
      if (held_count >= cap) begin
        o           = tail_slot;
        r.evicted   = 1'b1;
        r.evicted_x = keys_x[o];
        r.evicted_y = keys_y[o];
        r.evicted_z = keys_z[o];
        held[o]     = 1'b0;
        if (held_count > 1) tail_slot = newer[o];
        held_count--;
      end
    end
    r.slot      = SlotWidth'(s);
    r.occupancy = OccWidth'(held_count);
    return r;
  endfunction

  function automatic int compare_result(result_t e, result_t a);
    int errs;
    errs = 0;
    if (a.key_x !== e.key_x) begin
      $display("%t key_x expected %0d actual %0d", $realtime, e.key_x, a.key_x); errs++;
    end
    if (a.key_y !== e.key_y) begin
      $display("%t key_y expected %0d actual %0d", $realtime, e.key_y, a.key_y); errs++;
    end
    if (a.key_z !== e.key_z) begin
      $display("%t key_z expected %0d actual %0d", $realtime, e.key_z, a.key_z); errs++;
    end
    if (a.hit !== e.hit) begin
      $display("%t hit expected %0d actual %0d", $realtime, e.hit, a.hit); errs++;
    end
    if (a.slot !== e.slot) begin
      $display("%t slot expected %0d actual %0d", $realtime, e.slot, a.slot); errs++;
    end
    if (a.evicted !== e.evicted) begin
      $display("%t evicted expected %0d actual %0d", $realtime, e.evicted, a.evicted); errs++;
    end
    if (a.evicted_x !== e.evicted_x) begin
      $display("%t evicted_x expected %0d actual %0d", $realtime, e.evicted_x, a.evicted_x);
      errs++;
    end
    if (a.evicted_y !== e.evicted_y) begin
      $display("%t evicted_y expected %0d actual %0d", $realtime, e.evicted_y, a.evicted_y);
      errs++;
    end
    if (a.evicted_z !== e.evicted_z) begin
      $display("%t evicted_z expected %0d actual %0d", $realtime, e.evicted_z, a.evicted_z);
      errs++;
    end
    if (a.occupancy !== e.occupancy) begin
      $display("%t occupancy expected %0d actual %0d", $realtime, e.occupancy, a.occupancy);
      errs++;
    end
    return errs;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    cfg_t    c;
    result_t e;
    if (!rst_ni) begin
      inv_res    <= InvResReset;
      cap_reg    <= CapacityReset;
      head_slot  = 0;
      tail_slot  = 0;
      held_count = 0;
      for (int i = 0; i < TableDepth; i++) begin
        held[i]  = 1'b0;
        newer[i] = 0;
        older[i] = 0;
      end
      expected_results.delete();
      fail_count_o <= 0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        c = cfg_i.data;
        if (c.index == RegInvRes) inv_res <= c.value[InvWidth-1:0];
        else if (c.index == RegCapacity) cap_reg <= c.value[CapWidth-1:0];
      end
      if (result_i.valid && result_i.ready) begin
        if (expected_results.size() == 0) begin
          $display("%t result transaction with nothing expected, actual %h",
                   $realtime, result_i.data);
          fail_count_o <= fail_count_o + 1;
        end else begin
          e = expected_results.pop_front();
          if (compare_result(e, result_i.data) != 0) fail_count_o <= fail_count_o + 1;
        end
      end
      if (point_i.valid && point_i.ready) expected_results.push_back(lookup_point(point_i.data));
    end
  end

endmodule

// File: verif/tb_lru_voxel_key_table_core.sv
// ----------------------------------------------------------------------------
// tb_lru_voxel_key_table_core
// Drives points and register writes into the LRU voxel key table under several
// idle patterns and settings, and reports the verdict of the result checker.
// ----------------------------------------------------------------------------
module tb_lru_voxel_key_table_core;
  import lvkt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 4000000;
  localparam int PoolSize   = 12;
  localparam int NumPhases  = 8;

  logic clk_i;
  logic rst_ni;
  int   fail_count;
  int   pending;
  int   cycles;
  int   tx_idle_pct;
  int   rx_stall_pct;
  point_t point_pool[PoolSize];

  lvkt_stream_if #(.data_t(cfg_t))    cfg_if ();
  lvkt_stream_if #(.data_t(point_t))  point_if ();
  lvkt_stream_if #(.data_t(result_t)) result_if ();

  lru_voxel_key_table_core uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_if),
    .point_i (point_if),
    .result_o(result_if)
  );

  lvkt_result_checker checker_i (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_if),
    .point_i     (point_if),
    .result_i    (result_if),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("** lru_voxel_key_table_core: FAILED **");
      $finish;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_if.ready <= 1'b0;
    end else begin
      result_if.ready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  function automatic logic signed [CoordWidth-1:0] random_coord();
    logic signed [CoordWidth-1:0] c;
    if ($urandom_range(0, 3) == 0) return CoordWidth'($urandom);
    c = CoordWidth'(int'($urandom_range(0, 4095)) - 2048);
    return c <<< $urandom_range(0, 11);
  endfunction

  function automatic point_t random_point();
    point_t p;
    p.point_x = random_coord();
    p.point_y = random_coord();
    p.point_z = random_coord();
    return p;
  endfunction

  task automatic send_point(point_t p);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      point_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    point_if.valid <= 1'b1;
    point_if.data  <= p;
    do @(posedge clk_i); while (!point_if.ready);
  endtask

  task automatic write_reg(logic [CfgIdxWidth-1:0] idx, logic [CfgDataWidth-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= '{index: idx, value: val};
    do @(posedge clk_i); while (!cfg_if.ready);
  endtask

  task automatic drain();
    point_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic send_coords(int x, int y, int z);
    point_t p;
    p.point_x = CoordWidth'(x);
    p.point_y = CoordWidth'(y);
    p.point_z = CoordWidth'(z);
    send_point(p);
  endtask

  initial begin
    logic [CfgDataWidth-1:0] inv_tab [NumPhases];
    logic [CfgDataWidth-1:0] cap_tab [NumPhases];
    int                      cnt_tab [NumPhases];
    inv_tab = '{16'd256, 16'd65535, 16'd1, 16'hFFFF, 16'd512, 16'hFFFF, 16'd128, 16'hFFFF};
    cap_tab = '{16'd2, 16'd0, 16'd1, 16'd3, 16'd8, 16'd64, 16'd16, 16'hFFFF};
    cnt_tab = '{200, 150, 150, 250, 300, 300, 250, 300};
    cycles          = 0;
    tx_idle_pct     = 0;
    rx_stall_pct    = 0;
    cfg_if.valid    <= 1'b0;
    cfg_if.data     <= '0;
    point_if.valid  <= 1'b0;
    point_if.data   <= '0;
    rst_ni          = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: extremes, rounding halves, hits in every list position
    send_coords(0, 0, 0);
    send_coords(8388607, 8388607, 8388607);
    send_coords(-8388608, -8388608, -8388608);
    send_coords(64, -64, 63);
    send_coords(-63, 65, -65);
    send_coords(0, 0, 0);
    send_coords(64, -64, 63);
    send_coords(8388607, -8388608, 1);
    send_coords(8388607, 8388607, 8388607);
    send_coords(200, 0, -200);
    send_coords(8388607, -8388608, 1);
    send_coords(-8388608, -8388608, -8388608);
    send_coords(0, 0, 0);
    send_coords(0, 0, 0);
    drain();

    // zero inverse resolution with capacity one: every key collapses to zero
    write_reg(RegInvRes, 16'd0);
    write_reg(RegCapacity, 16'd1);
    cfg_if.valid <= 1'b0;
    @(posedge clk_i);
    send_coords(8388607, -8388608, 12345);
    send_coords(-1, 1, 0);
    send_coords(100, 200, 300);
    drain();

    for (int ph = 0; ph < NumPhases; ph++) begin
      write_reg(RegInvRes, (inv_tab[ph] == 16'hFFFF && ph != 1) ? 16'($urandom_range(1, 65535))
                                                                : inv_tab[ph]);
      write_reg(RegCapacity, cap_tab[ph]);
      if (ph == 3) write_reg(CfgIdxWidth'(15), 16'($urandom));
      cfg_if.valid <= 1'b0;
      case (ph % 4)
        0: begin
          tx_idle_pct  = 0;
          rx_stall_pct = 0;
        end
        1: begin
          tx_idle_pct  = 67;
          rx_stall_pct = 0;
        end
        2: begin
          tx_idle_pct  = 0;
          rx_stall_pct = 67;
        end
        default: begin
          tx_idle_pct  = 18;
          rx_stall_pct = 18;
        end
      endcase
      for (int i = 0; i < PoolSize; i++) point_pool[i] = random_point();
      @(posedge clk_i);
      for (int n = 0; n < cnt_tab[ph]; n++) begin
        if ($urandom_range(0, 9) < 7) send_point(point_pool[$urandom_range(0, PoolSize - 1)]);
        else send_point(random_point());
      end
      drain();
    end

    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    repeat (50) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("** lru_voxel_key_table_core: PASSED **");
    end else begin
      $display("** lru_voxel_key_table_core: FAILED **");
    end
    $finish;
  end

endmodule
